### src/rtp_pkg.sv
// rtp_pkg: shared types and character/radix constants for the radix integer
// text parser. No dependencies; used by every file under src.
package rtp_pkg;

  localparam int CH_W     = 8;
  localparam int RADIX_W  = 6;
  localparam int OFFSET_W = 12;
  localparam int OUT_VAL_W = 64;

  // Input item: one character plus string framing flags
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
    logic            last;
  } in_item_t;

  // Result item: one per string
  typedef struct packed {
    logic [OUT_VAL_W-1:0] value;
    logic [OFFSET_W-1:0]  end_offset;
    logic                 no_digits;
  } out_item_t;

  // Character classification handed from the decoder to the parse step
  typedef struct packed {
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic [RADIX_W-1:0] digit;
  } char_class_t;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_START  = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'h3F;
  localparam logic [RADIX_W-1:0] DIGIT_ALPHA = 6'd10;

  localparam logic [OFFSET_W-1:0] OFFSET_CAP = 12'hFFF;

endpackage

### src/radix_integer_text_parser.sv
// radix_integer_text_parser: streaming strtoul-style integer parser, top level.
// Depends on rtp_pkg and rtp_char_class.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item): one character per transfer,
//   with first marking the opening character of a string and last the final
//   one. Characters outside a string (no first seen, or result already given)
//   are dropped. A first flag mid-string drops the string in progress.
//   Result channel (out_valid / out_stall / out_item): one result per string,
//   produced at the first rejected character or at the last character.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes radix_select
//   (0 = auto-detect, 2..36). Always ready; write only while the block is idle.
// Timing:
//   An input transfer lands in the input register; the parse step then updates the
//   string state and loads the output register when a result is due, unless a stalled
//   result still waits there. One character is taken every cycle while no result waits
//   under out_stall; the step is one accumulator multiply-add by the radix.
// Reset: synchronous, active low; radix returns to 10, parser idle, registers empty.
// Stall: while a result waits under out_stall, one more character is taken
//   into the input register, then in_stall rises until the result transfers.
module radix_integer_text_parser #(
  parameter int MAX_LEN     = 4095,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rtp_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rtp_pkg::out_item_t           out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rtp_pkg::RADIX_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int EW = (CW > rtp_pkg::OFFSET_W) ? CW : rtp_pkg::OFFSET_W;

  // Configuration
  logic [rtp_pkg::RADIX_W-1:0] radix_select_r;

  // Input register
  logic               s1_valid_r;
  rtp_pkg::in_item_t  s1_item_r;

  // String state
  rtp_pkg::phase_t             phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]      acc_r, acc_nxt;
  logic                        minus_r, minus_nxt;
  logic [rtp_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               dend_r, dend_nxt;

  // Output register
  logic               out_valid_r;
  rtp_pkg::out_item_t out_item_r, out_item_nxt;

  logic advance, fire, emit;
  rtp_pkg::char_class_t cls;

  // Effective state after the first flag is applied
  rtp_pkg::phase_t             ph_e;
  logic [VALUE_WIDTH-1:0]      acc_e;
  logic                        minus_e;
  logic [rtp_pkg::RADIX_W-1:0] rad_e;
  logic [CW-1:0]               cnt_e, dend_e, cnt_sat;
  logic                        start_path, try_digit, reject, radix_ok;
  logic [VALUE_WIDTH-1:0]      signed_val;
  logic [EW-1:0]               dend_ext;

  assign cfg_ready = 1'b1;

  // Step the string state only when a result could be placed
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rtp_char_class u_cls (
    .ch  (s1_item_r.ch),
    .cls (cls)
  );

  always_comb begin
    // Apply the first flag: open a fresh string
    if (s1_item_r.first) begin
      ph_e    = rtp_pkg::PH_LEAD;
      acc_e   = '0;
      minus_e = 1'b0;
      rad_e   = radix_select_r;
      cnt_e   = '0;
      dend_e  = '0;
    end else begin
      ph_e    = phase_r;
      acc_e   = acc_r;
      minus_e = minus_r;
      rad_e   = radix_r;
      cnt_e   = cnt_r;
      dend_e  = dend_r;
    end

    cnt_sat    = (cnt_e == CW'(MAX_LEN)) ? cnt_e : cnt_e + CW'(1);
    phase_nxt  = ph_e;
    acc_nxt    = acc_e;
    minus_nxt  = minus_e;
    radix_nxt  = rad_e;
    cnt_nxt    = cnt_e;
    dend_nxt   = dend_e;
    start_path = 1'b0;
    try_digit  = 1'b0;
    reject     = 1'b0;
    emit       = 1'b0;

    unique case (ph_e)
      rtp_pkg::PH_LEAD: begin
        if (cls.is_space) begin
          // skip leading whitespace
        end else if (cls.is_plus || cls.is_minus) begin
          minus_nxt = cls.is_minus;
          phase_nxt = rtp_pkg::PH_START;
        end else begin
          start_path = 1'b1;
        end
      end
      rtp_pkg::PH_START:  start_path = 1'b1;
      rtp_pkg::PH_ZERO: begin
        if (cls.is_x) begin
          radix_nxt = rtp_pkg::RADIX_HEX;
          phase_nxt = rtp_pkg::PH_DIGITS;
        end else begin
          if (rad_e == rtp_pkg::RADIX_AUTO) radix_nxt = rtp_pkg::RADIX_OCT;
          try_digit = 1'b1;
        end
      end
      rtp_pkg::PH_DIGITS: try_digit = 1'b1;
      default: ;
    endcase

    // Leading zero in auto or hex mode counts as a digit and may open a prefix
    if (start_path) begin
      if (cls.is_zero &&
          (rad_e == rtp_pkg::RADIX_AUTO || rad_e == rtp_pkg::RADIX_HEX)) begin
        acc_nxt   = '0;
        dend_nxt  = cnt_sat;
        phase_nxt = rtp_pkg::PH_ZERO;
      end else begin
        if (rad_e == rtp_pkg::RADIX_AUTO) radix_nxt = rtp_pkg::RADIX_DEC;
        try_digit = 1'b1;
      end
    end

    radix_ok = (radix_nxt >= rtp_pkg::RADIX_MIN) && (radix_nxt <= rtp_pkg::RADIX_MAX);
    if (try_digit) begin
      if (radix_ok && (cls.digit < radix_nxt)) begin
        acc_nxt   = acc_e * VALUE_WIDTH'(radix_nxt) + VALUE_WIDTH'(cls.digit);
        dend_nxt  = cnt_sat;
        phase_nxt = rtp_pkg::PH_DIGITS;
      end else begin
        reject = 1'b1;
      end
    end

    if (reject) begin
      emit      = 1'b1;
      phase_nxt = rtp_pkg::PH_DONE;
    end else begin
      cnt_nxt = cnt_sat;
      if (s1_item_r.last) begin
        emit      = 1'b1;
        phase_nxt = rtp_pkg::PH_DONE;
      end
    end

    // Characters outside a string produce no result
    if (ph_e == rtp_pkg::PH_IDLE || ph_e == rtp_pkg::PH_DONE) begin
      emit = 1'b0;
    end

    // Result formatting
    signed_val = minus_nxt ? (VALUE_WIDTH'(0) - acc_nxt) : acc_nxt;
    dend_ext   = EW'(dend_nxt);
    if (dend_nxt != '0) begin
      out_item_nxt.value      = rtp_pkg::OUT_VAL_W'(signed_val);
      out_item_nxt.end_offset = (dend_ext > EW'(rtp_pkg::OFFSET_CAP)) ?
                                rtp_pkg::OFFSET_CAP : dend_ext[rtp_pkg::OFFSET_W-1:0];
      out_item_nxt.no_digits  = 1'b0;
    end else begin
      out_item_nxt.value      = '0;
      out_item_nxt.end_offset = '0;
      out_item_nxt.no_digits  = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_select_r <= rtp_pkg::RADIX_RESET;
      s1_valid_r     <= 1'b0;
      phase_r        <= rtp_pkg::PH_IDLE;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix_select_r <= cfg_data;
      end
      // Input register: take a transfer, or drain when the step advances
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        phase_r <= phase_nxt;
      end
      // Output register: load a result, drop once transferred
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and string data
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
      radix_r <= radix_nxt;
      cnt_r   <= cnt_nxt;
      dend_r  <= dend_nxt;
    end
    if (fire && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

### src/rtp_char_class.sv
// rtp_char_class: decodes one character into whitespace/sign/prefix flags
// and its digit value (0..35, or none). Depends on rtp_pkg.
module rtp_char_class (
  input  logic [rtp_pkg::CH_W-1:0] ch,
  output rtp_pkg::char_class_t     cls
);

  always_comb begin
    cls.is_space = (ch == rtp_pkg::CH_SPACE) || (ch == rtp_pkg::CH_TAB) ||
                   (ch == rtp_pkg::CH_LF)    || (ch == rtp_pkg::CH_CR);
    cls.is_plus  = (ch == rtp_pkg::CH_PLUS);
    cls.is_minus = (ch == rtp_pkg::CH_MINUS);
    cls.is_zero  = (ch == rtp_pkg::CH_0);
    cls.is_x     = (ch == rtp_pkg::CH_LX) || (ch == rtp_pkg::CH_UX);
    if (ch >= rtp_pkg::CH_0 && ch <= rtp_pkg::CH_9) begin
      cls.digit = rtp_pkg::RADIX_W'(ch - rtp_pkg::CH_0);
    end else if (ch >= rtp_pkg::CH_LA && ch <= rtp_pkg::CH_LZ) begin
      cls.digit = rtp_pkg::RADIX_W'(ch - rtp_pkg::CH_LA) + rtp_pkg::DIGIT_ALPHA;
    end else if (ch >= rtp_pkg::CH_UA && ch <= rtp_pkg::CH_UZ) begin
      cls.digit = rtp_pkg::RADIX_W'(ch - rtp_pkg::CH_UA) + rtp_pkg::DIGIT_ALPHA;
    end else begin
      cls.digit = rtp_pkg::DIGIT_NONE;
    end
  end

endmodule

### src/rtp_checker.sv
// rtp_checker: port-level assertions for radix_integer_text_parser, with the
// bind that attaches it. Depends on rtp_pkg and the top level.
module rtp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input rtp_pkg::in_item_t           in_item,
  input logic                        out_valid,
  input logic                        out_stall,
  input rtp_pkg::out_item_t          out_item
);

  // A result under stall holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // End offset is nonzero exactly when digits were read; no digits means zero value
  a_offset_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.no_digits == (out_item.end_offset == '0)) &&
                  (!out_item.no_digits || out_item.value == '0))
    else $error("no_digits disagrees with end_offset or value");

  // A stalled character holds until transferred
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input changed or dropped while stalled");

  // Input back-pressure only while a result waits under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind radix_integer_text_parser rtp_checker u_rtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### test/tb_radix_integer_text_parser.sv
// tb_radix_integer_text_parser: self-checking testbench for the streaming integer parser.
// Depends on rtp_pkg and the radix_integer_text_parser top level under src.
// A scoreboard class predicts one result per string; plain tasks drive the channels.
module tb_radix_integer_text_parser;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 8;
  localparam int unsigned MAX_CHARS = 4095;
  localparam int PHASE_COUNT    = 14;
  localparam int PHASE_ITEMS    = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_LEN       = 64;
  localparam int LONG_PHASE     = 3;
  localparam int TIMEOUT_CYCLES = 600000;

  // Radix settings outside the legal range, used to check the no-digit path
  localparam logic [rtp_pkg::RADIX_W-1:0] RADIX_ONE  = 6'd1;
  localparam logic [rtp_pkg::RADIX_W-1:0] RADIX_OVER = 6'd37;
  localparam logic [rtp_pkg::RADIX_W-1:0] RADIX_TOP  = 6'd63;

  // Predicts the parser: string state, configured radix, and the results still owed.
  class parse_scoreboard;
    rtp_pkg::out_item_t            expected_results[$];
    int unsigned                   errors;
    logic [rtp_pkg::RADIX_W-1:0]   radix_reg;
    rtp_pkg::phase_t               phase;
    logic [rtp_pkg::OUT_VAL_W-1:0] acc;
    bit                            minus;
    logic [rtp_pkg::RADIX_W-1:0]   act_radix;
    int unsigned                   char_cnt;
    int unsigned                   digit_end;

    function new();
      errors    = 0;
      radix_reg = rtp_pkg::RADIX_RESET;
      phase     = rtp_pkg::PH_IDLE;
      acc       = '0;
      minus     = 1'b0;
      act_radix = '0;
      char_cnt  = 0;
      digit_end = 0;
    endfunction

    function void set_radix(logic [rtp_pkg::RADIX_W-1:0] r);
      radix_reg = r;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int unsigned clip_len(int unsigned v);
      return (v > MAX_CHARS) ? MAX_CHARS : v;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_char(rtp_pkg::in_item_t it);
      logic [rtp_pkg::CH_W-1:0]    c;
      logic [rtp_pkg::RADIX_W-1:0] d;
      int unsigned                 pos;
      rtp_pkg::phase_t             step;
      bit                          taken;
      bit                          rejected;
      rtp_pkg::out_item_t          res;
      c = it.ch;
      if (it.first) begin
        phase     = rtp_pkg::PH_LEAD;
        acc       = '0;
        minus     = 1'b0;
        act_radix = radix_reg;
        char_cnt  = 0;
        digit_end = 0;
      end else if (phase == rtp_pkg::PH_IDLE || phase == rtp_pkg::PH_DONE) begin
        return;
      end
      pos      = char_cnt;
      step     = phase;
      taken    = 1'b0;
      rejected = 1'b0;

      if (step == rtp_pkg::PH_LEAD) begin
        if (c == rtp_pkg::CH_SPACE || c == rtp_pkg::CH_TAB ||
            c == rtp_pkg::CH_LF || c == rtp_pkg::CH_CR) begin
          taken = 1'b1;
        end else if (c == rtp_pkg::CH_PLUS || c == rtp_pkg::CH_MINUS) begin
          minus = (c == rtp_pkg::CH_MINUS);
          phase = rtp_pkg::PH_START;
          taken = 1'b1;
        end else begin
          step = rtp_pkg::PH_START;
        end
      end
      if (!taken) begin
        if (step == rtp_pkg::PH_START) begin
          if (c == rtp_pkg::CH_0 && (act_radix == rtp_pkg::RADIX_AUTO ||
                                     act_radix == rtp_pkg::RADIX_HEX)) begin
            acc       = '0;
            digit_end = clip_len(pos + 1);
            phase     = rtp_pkg::PH_ZERO;
            taken     = 1'b1;
          end else begin
            if (act_radix == rtp_pkg::RADIX_AUTO) act_radix = rtp_pkg::RADIX_DEC;
            step = rtp_pkg::PH_DIGITS;
          end
        end else if (step == rtp_pkg::PH_ZERO) begin
          if (c == rtp_pkg::CH_LX || c == rtp_pkg::CH_UX) begin
            act_radix = rtp_pkg::RADIX_HEX;
            phase     = rtp_pkg::PH_DIGITS;
            taken     = 1'b1;
          end else begin
            if (act_radix == rtp_pkg::RADIX_AUTO) act_radix = rtp_pkg::RADIX_OCT;
            step = rtp_pkg::PH_DIGITS;
          end
        end
      end
      if (!taken && step == rtp_pkg::PH_DIGITS) begin
        if (c >= rtp_pkg::CH_0 && c <= rtp_pkg::CH_9) begin
          d = rtp_pkg::RADIX_W'(c - rtp_pkg::CH_0);
        end else if (c >= rtp_pkg::CH_LA && c <= rtp_pkg::CH_LZ) begin
          d = rtp_pkg::RADIX_W'(c - rtp_pkg::CH_LA) + rtp_pkg::DIGIT_ALPHA;
        end else if (c >= rtp_pkg::CH_UA && c <= rtp_pkg::CH_UZ) begin
          d = rtp_pkg::RADIX_W'(c - rtp_pkg::CH_UA) + rtp_pkg::DIGIT_ALPHA;
        end else begin
          d = rtp_pkg::DIGIT_NONE;
        end
        if (act_radix >= rtp_pkg::RADIX_MIN && act_radix <= rtp_pkg::RADIX_MAX &&
            d < act_radix) begin
          acc       = acc * rtp_pkg::OUT_VAL_W'(act_radix) + rtp_pkg::OUT_VAL_W'(d);
          digit_end = clip_len(pos + 1);
          phase     = rtp_pkg::PH_DIGITS;
        end else begin
          rejected = 1'b1;
        end
      end

      if (!rejected) char_cnt = clip_len(pos + 1);
      if (rejected || it.last) begin
        res.no_digits  = (digit_end == 0);
        res.value      = res.no_digits ? '0 : (minus ? -acc : acc);
        res.end_offset = res.no_digits ? '0 :
                         ((digit_end > rtp_pkg::OFFSET_CAP) ? rtp_pkg::OFFSET_CAP :
                          rtp_pkg::OFFSET_W'(digit_end));
        expected_results.push_back(res);
        phase = rtp_pkg::PH_DONE;
      end
    endfunction

    task check_result(rtp_pkg::out_item_t got);
      rtp_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected: value %h end %0d",
                         got.value, got.end_offset));
        return;
      end
      want = expected_results.pop_front();
      if (got.value !== want.value)
        report($sformatf("value %h, expected %h", got.value, want.value));
      if (got.end_offset !== want.end_offset)
        report($sformatf("end_offset %0d, expected %0d", got.end_offset, want.end_offset));
      if (got.no_digits !== want.no_digits)
        report($sformatf("no_digits %b, expected %b", got.no_digits, want.no_digits));
    endtask
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  rtp_pkg::in_item_t           in_item   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  rtp_pkg::out_item_t          out_item;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [rtp_pkg::RADIX_W-1:0] cfg_data  = '0;

  parse_scoreboard sb = new();

  // Idle control: per-side calm stretches, a no-gap override for the long run,
  // and a request for the result side to hold off for a long stretch.
  int sender_calm  = 0;
  int sink_calm    = 0;
  bit no_gaps      = 1'b0;
  bit hold_off_req = 1'b0;

  radix_integer_text_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Draw an idle count from 0 to 14; now and then start a run of zero-idle items.
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic rtp_pkg::in_item_t mk_char(logic [rtp_pkg::CH_W-1:0] c, bit f, bit l);
    rtp_pkg::in_item_t it;
    it.ch    = c;
    it.first = f;
    it.last  = l;
    return it;
  endfunction

  // Character for digit value d; letters come in either case.
  function automatic logic [rtp_pkg::CH_W-1:0] digit_char(int unsigned d);
    if (d < rtp_pkg::DIGIT_ALPHA) return rtp_pkg::CH_0 + rtp_pkg::CH_W'(d);
    return ($urandom_range(0, 1) ? rtp_pkg::CH_LA : rtp_pkg::CH_UA) +
           rtp_pkg::CH_W'(d - rtp_pkg::DIGIT_ALPHA);
  endfunction

  // Offer one character, hold it until the transfer, then note it for prediction.
  // Valid stays high on return so a back-to-back item needs no extra edge.
  task automatic send_item(rtp_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_char(it);
  endtask

  // Send a string with first on its opening character and, if asked, last on the final one.
  task automatic send_text(string s, bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_item(mk_char(s[i], i == 0, mark_last && (i == s.len() - 1)));
  endtask

  // Drop valid, wait for every owed result, then let the pipeline empty out:
  // trailing characters that cause no result may still sit in the input register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the radix register only with the block idle.
  task automatic write_radix(logic [rtp_pkg::RADIX_W-1:0] r);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_radix(r);
  endtask

  // Result side: stall for a drawn number of cycles, then take one transfer.
  // On request, hold off for a long stretch so the block backs up into in_stall.
  initial begin : result_sink
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = draw_wait(sink_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin : stimulus
    logic [rtp_pkg::RADIX_W-1:0] phase_radix [9];
    logic [rtp_pkg::RADIX_W-1:0] radix;
    logic [rtp_pkg::RADIX_W-1:0] eff;
    logic [rtp_pkg::CH_W-1:0]    text[$];
    int                          phase_items;
    int                          n;
    int                          ending;
    bit                          mark_last;

    phase_radix = '{rtp_pkg::RADIX_AUTO, rtp_pkg::RADIX_HEX, rtp_pkg::RADIX_DEC,
                    rtp_pkg::RADIX_MIN, rtp_pkg::RADIX_MAX, rtp_pkg::RADIX_OCT,
                    RADIX_ONE, RADIX_OVER, RADIX_TOP};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset radix (decimal) first.
    send_item(mk_char(8'hFF, 1'b1, 1'b1));           // top byte alone: no digits
    send_text(" \t+9", 1'b1);                        // skip whitespace, plus sign
    send_text("--", 1'b0);                           // second sign is rejected
    send_item(mk_char(rtp_pkg::CH_LX, 1'b0, 1'b0));  // after the result: dropped
    send_text("5", 1'b0);                            // abandoned by the next first flag
    send_text("7", 1'b1);
    send_text("4", 1'b0);
    send_item(mk_char(8'h00, 1'b0, 1'b0));           // terminator ends the number
    send_text("-1", 1'b1);                           // negation wraps to all ones

    // Auto-detect: hex prefix with no digit, and a lone zero ahead of a non-octal digit.
    write_radix(rtp_pkg::RADIX_AUTO);
    send_text("0xg", 1'b0);
    send_text("09", 1'b0);

    // Hex: whitespace after the sign, and a zero ahead of an out-of-range letter.
    write_radix(rtp_pkg::RADIX_HEX);
    send_text("- ", 1'b0);
    send_text("0Z", 1'b0);

    // Illegal radix takes no digit at all.
    write_radix(RADIX_ONE);
    send_text("7", 1'b1);

    // Random part: one radix setting per phase, mostly well-formed strings.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 9)           radix = phase_radix[p];
      else if (p % 2 == 0) radix = rtp_pkg::RADIX_W'($urandom_range(2, 36));
      else                 radix = rtp_pkg::RADIX_W'($urandom_range(0, 63));
      write_radix(radix);

      // Back the block up twice while the sender keeps offering.
      if (p == 2 || p == 7) hold_off_req = 1'b1;

      // One long digit run sent without gaps.
      if (p == LONG_PHASE) begin
        no_gaps = 1'b1;
        for (int i = 0; i < LONG_LEN; i++)
          send_item(mk_char(digit_char($urandom_range(0, 1)), i == 0, i == LONG_LEN - 1));
        no_gaps = 1'b0;
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 2) begin
          // Noise: random bytes with loosely placed framing flags.
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            send_item(mk_char(rtp_pkg::CH_W'($urandom_range(0, 255)),
                              (i == 0) ? ($urandom_range(0, 9) != 0) :
                                         ($urandom_range(0, 15) == 0),
                              $urandom_range(0, 3) == 0));
          phase_items += n;
        end else begin
          text.delete();
          n = $urandom_range(0, 5);
          if (n > 3) n = 0;
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
              0:       text.push_back(rtp_pkg::CH_SPACE);
              1:       text.push_back(rtp_pkg::CH_TAB);
              2:       text.push_back(rtp_pkg::CH_LF);
              default: text.push_back(rtp_pkg::CH_CR);
            endcase
          end
          case ($urandom_range(0, 2))
            1:       text.push_back(rtp_pkg::CH_PLUS);
            2:       text.push_back(rtp_pkg::CH_MINUS);
            default: ;
          endcase

          // Pick the prefix and the radix that the digits are drawn from.
          eff = radix;
          if (radix == rtp_pkg::RADIX_AUTO) begin
            case ($urandom_range(0, 2))
              0: begin
                text.push_back(rtp_pkg::CH_0);
                text.push_back($urandom_range(0, 1) ? rtp_pkg::CH_LX : rtp_pkg::CH_UX);
                eff = rtp_pkg::RADIX_HEX;
              end
              1: begin
                text.push_back(rtp_pkg::CH_0);
                eff = rtp_pkg::RADIX_OCT;
              end
              default: eff = rtp_pkg::RADIX_DEC;
            endcase
          end else if (radix == rtp_pkg::RADIX_HEX && $urandom_range(0, 1)) begin
            text.push_back(rtp_pkg::CH_0);
            text.push_back($urandom_range(0, 1) ? rtp_pkg::CH_LX : rtp_pkg::CH_UX);
          end else if (radix < rtp_pkg::RADIX_MIN || radix > rtp_pkg::RADIX_MAX) begin
            eff = rtp_pkg::RADIX_MAX;
          end

          n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
          for (int i = 0; i < n; i++) text.push_back(digit_char($urandom_range(0, eff - 1)));

          // End on last, on a stray character, or not at all (the next first drops it).
          ending    = $urandom_range(0, 9);
          mark_last = (ending < 4) || (ending < 8 && $urandom_range(0, 1));
          if (ending >= 4 && ending < 8)
            text.push_back(($urandom_range(0, 2) == 0) ? 8'h00 :
                           rtp_pkg::CH_W'($urandom_range(0, 255)));
          if (text.size() == 0) text.push_back(rtp_pkg::CH_W'($urandom_range(0, 255)));

          foreach (text[i])
            send_item(mk_char(text[i], i == 0, mark_last && (i == text.size() - 1)));
          phase_items += text.size();

          // Trailing characters past the end of a string: mostly dropped.
          if (ending >= 4 && ending < 8 && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
              send_item(mk_char(rtp_pkg::CH_W'($urandom_range(0, 255)), 1'b0, 1'b0));
          end
        end
      end
    end

    settle();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

endmodule
